/* src/humidity_temp_frame_decoder_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the humidity/temperature frame decoder
// Concurrent checks sampled on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_UNIT_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Condition must hold at every sampled edge out of reset.
`define HTFD_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("htfd assertion failed");
// Consequent must hold at the edge after the antecedent.
`define HTFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htfd assertion failed");
`else
`define HTFD_ASSERT(label, cond)
`define HTFD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* src/htfd_pkg.sv */
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 byte step for the frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

  // CRC-8 settings of the sensor check byte.
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Scaling constants, values in hundredths.
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] HUM_SPAN    = 15'd10000;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;

  // Quantity codes carried with each result.
  localparam logic QTY_TEMP = 1'b0;
  localparam logic QTY_HUM  = 1'b1;

  // One measurement word handed from the front to the back.
  typedef struct packed {
    logic        quantity;
    logic [15:0] raw_word;
    logic [7:0]  check;
    logic [7:0]  crc_hi;
  } mid_rec_t;

  // One finished result.
  typedef struct packed {
    logic               quantity;
    logic [15:0]        raw_word;
    logic               crc_good;
    logic signed [14:0] scaled_value;
    logic               frame_done;
  } res_rec_t;

  // Queue status toward its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // One byte of MSB-first CRC-8, eight shift steps.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] c;
    int         b;
    c = crc_in ^ data;
    for (b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* src/htfd_fifo.sv */
// ----------------------------------------------------------------------------
// htfd_fifo
// Small register queue with registered storage, used between the front and
// the back and as the result register stage.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decoder_unit_macros.svh"

module htfd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   pop,
  output logic [WIDTH-1:0]       rdata,
  output htfd_pkg::fifo_stat_t   stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r, wr_nxt;
  logic [AW-1:0]    rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  // Pointer wrap at the configured depth.
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : AW'(wr_r + 1'b1);
    end
    if (pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : AW'(rd_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage, written one beat at a time.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rd_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  // Neighbors never push into a full queue or pop an empty one.
  `HTFD_ASSERT(a_no_overflow, !(push && stat.full))
  `HTFD_ASSERT(a_no_underflow, !(pop && stat.empty))
  // Occupancy follows the beats in and out.
  `HTFD_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == CW'($past(cnt_r) + 1'b1))
  `HTFD_ASSERT_NEXT(a_cnt_down, pop && !push, cnt_r == CW'($past(cnt_r) - 1'b1))

endmodule

/* src/htfd_front.sv */
// ----------------------------------------------------------------------------
// htfd_front
// Tracks the byte position in the six-byte frame, holds the word bytes and
// the partial CRC, and hands a word record to the back on each check byte.
// ----------------------------------------------------------------------------
module htfd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  output logic                 rec_push,
  output htfd_pkg::mid_rec_t   rec
);

  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CHK = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CHK = 3'd5
  } pos_t;

  pos_t       pos_r;
  logic [7:0] hi_r;
  logic [7:0] lo_r;
  logic [7:0] crc_hi_r;

  // Position sequencer plus the held word; only the position is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_T_HI;
    end else if (accept) begin
      unique case (pos_r)
        POS_T_LO: begin
          lo_r  <= data_byte;
          pos_r <= POS_T_CHK;
        end
        POS_T_CHK: begin
          pos_r <= POS_H_HI;
        end
        POS_H_HI: begin
          hi_r     <= data_byte;
          crc_hi_r <= htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, data_byte);
          pos_r    <= POS_H_LO;
        end
        POS_H_LO: begin
          lo_r  <= data_byte;
          pos_r <= POS_H_CHK;
        end
        POS_H_CHK: begin
          pos_r <= POS_T_HI;
        end
        default: begin
          // Start of frame; unused codes behave the same way.
          hi_r     <= data_byte;
          crc_hi_r <= htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, data_byte);
          pos_r    <= POS_T_LO;
        end
      endcase
    end
  end

  // A check byte closes a word and produces one record.
  assign rec_push     = accept && ((pos_r == POS_T_CHK) || (pos_r == POS_H_CHK));
  assign rec.quantity = (pos_r == POS_H_CHK) ? htfd_pkg::QTY_HUM : htfd_pkg::QTY_TEMP;
  assign rec.raw_word = {hi_r, lo_r};
  assign rec.check    = data_byte;
  assign rec.crc_hi   = crc_hi_r;

endmodule

/* src/htfd_back.sv */
// ----------------------------------------------------------------------------
// htfd_back
// Finishes the CRC check and scales the raw word. One register stage holds
// the CRC verdict and the span product; the divide by 65535 and the offset
// are applied on the way into the result queue.
// ----------------------------------------------------------------------------
module htfd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  htfd_pkg::mid_rec_t     rec,
  input  htfd_pkg::fifo_stat_t   rec_stat,
  output logic                   rec_pop,
  output logic                   res_push,
  output htfd_pkg::res_rec_t     res,
  input  htfd_pkg::fifo_stat_t   res_stat
);

  logic        s1_v_r;
  logic        s1_qty_r;
  logic [15:0] s1_raw_r;
  logic        s1_good_r;
  logic [30:0] s1_prod_r;

  logic        s1_ready;
  logic [14:0] span;
  logic [31:0] quo_sum;
  logic [15:0] quo;
  logic [15:0] scaled;

  // Stage one moves when empty or when its result leaves.
  assign res_push = s1_v_r && !res_stat.full;
  assign s1_ready = !s1_v_r || !res_stat.full;
  assign rec_pop  = !rec_stat.empty && s1_ready;

  assign span = (rec.quantity == htfd_pkg::QTY_HUM) ? htfd_pkg::HUM_SPAN
                                                     : htfd_pkg::TEMP_SPAN;

  // Valid flag of stage one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rec_pop) begin
      s1_v_r <= 1'b1;
    end else if (res_push) begin
      s1_v_r <= 1'b0;
    end
  end

  // Stage one payload: CRC over the low byte and the span product.
  always_ff @(posedge clk) begin
    if (rec_pop) begin
      s1_qty_r  <= rec.quantity;
      s1_raw_r  <= rec.raw_word;
      s1_good_r <= (htfd_pkg::crc8_byte(rec.crc_hi, rec.raw_word[7:0]) == rec.check);
      s1_prod_r <= 31'(span * rec.raw_word);
    end
  end

  // floor(p / 65535) = (p + (p >> 16) + 1) >> 16 for the product range here.
  assign quo_sum = 32'(s1_prod_r) + 32'(s1_prod_r[30:16]) + 32'd1;
  assign quo     = quo_sum[31:16];
  assign scaled  = (s1_qty_r == htfd_pkg::QTY_HUM) ? quo
                                                   : 16'(quo - htfd_pkg::TEMP_OFFSET);

  assign res.quantity     = s1_qty_r;
  assign res.raw_word     = s1_raw_r;
  assign res.crc_good     = s1_good_r;
  assign res.scaled_value = scaled[14:0];
  assign res.frame_done   = (s1_qty_r == htfd_pkg::QTY_HUM);

endmodule

/* src/humidity_temp_frame_decoder_unit.sv */
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_unit
// Decodes the six-byte sensor frame into temperature and humidity results.
// ----------------------------------------------------------------------------
// Usage:
// Input side is a queue: drive in_data_byte and push; a beat is taken on a
// clock edge with push high and full low. Bytes follow the sensor frame order:
// temperature high, low, check, humidity high, low, check.
// Result side is a queue: while empty is low the oldest result sits on the
// out_ ports; pop high on a clock edge takes it.
// Each check byte yields one result (raw word, CRC verdict, scaled value);
// the humidity result carries out_frame_done.
// Path: a check byte accepted at a clock edge is written into the word queue
// at that edge, then into the CRC/product register and then into the result
// queue, where its result can be popped.
// Throughput: one byte per cycle while full is low; every stage takes a new
// beat each cycle while the stage after it has room.
// Reset (rst_n low, synchronous) returns to the start of a frame and empties
// both queues. When the receiver stops popping, the result queue fills, the
// product stage holds, the word queue fills and full rises to stall the input.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_unit #(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [7:0]         in_data_byte,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output logic               out_quantity,
  output logic [15:0]        out_raw_word,
  output logic               out_crc_good,
  output logic signed [14:0] out_scaled_value,
  output logic               out_frame_done
);

  htfd_pkg::mid_rec_t   front_rec;
  htfd_pkg::mid_rec_t   mid_rec;
  htfd_pkg::fifo_stat_t mid_stat;
  htfd_pkg::res_rec_t   back_res;
  htfd_pkg::res_rec_t   out_res;
  htfd_pkg::fifo_stat_t out_stat;
  logic                 accept;
  logic                 front_push;
  logic                 mid_pop;
  logic                 res_push;

  // Input beat is taken whenever the word queue has room.
  assign full   = mid_stat.full;
  assign accept = push && !full;

  htfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .rec_push  (front_push),
    .rec       (front_rec)
  );

  // Word queue between front and back.
  htfd_fifo #(
    .WIDTH ($bits(htfd_pkg::mid_rec_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_push),
    .wdata (front_rec),
    .pop   (mid_pop),
    .rdata (mid_rec),
    .stat  (mid_stat)
  );

  htfd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rec      (mid_rec),
    .rec_stat (mid_stat),
    .rec_pop  (mid_pop),
    .res_push (res_push),
    .res      (back_res),
    .res_stat (out_stat)
  );

  // Result queue doubles as the output register.
  htfd_fifo #(
    .WIDTH ($bits(htfd_pkg::res_rec_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .pop   (pop && !out_stat.empty),
    .rdata (out_res),
    .stat  (out_stat)
  );

  assign empty            = out_stat.empty;
  assign out_quantity     = out_res.quantity;
  assign out_raw_word     = out_res.raw_word;
  assign out_crc_good     = out_res.crc_good;
  assign out_scaled_value = out_res.scaled_value;
  assign out_frame_done   = out_res.frame_done;

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Testbench for humidity_temp_frame_decoder_unit
// Sends six-byte sensor frames through the input queue and checks every
// temperature and humidity result against a cycle-free model of the frame
// decoder: raw word, CRC-8 verdict, scaled value and frame-done flag.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_FRAMES = 230;

  // Expected results of the frame decoder and its byte position tracking.
  class frame_scoreboard;
    htfd_pkg::res_rec_t result_q[$];
    logic [2:0] position;
    logic [7:0] high_byte;
    logic [7:0] low_byte;
    int         errors;

    function new();
      position  = 3'd0;
      high_byte = 8'h00;
      low_byte  = 8'h00;
      errors    = 0;
    endfunction

    // MSB-first CRC-8 over one two-byte word.
    static function logic [7:0] word_crc(logic [7:0] hi, logic [7:0] lo);
      logic [7:0] c;
      logic [15:0] w;
      c = htfd_pkg::CRC_INIT;
      w = {hi, lo};
      for (int i = 15; i >= 0; i--) begin
        if (c[7] ^ w[i]) begin
          c = (c << 1) ^ htfd_pkg::CRC_POLY;
        end else begin
          c = c << 1;
        end
      end
      return c;
    endfunction

    // Build the result that a check byte closes.
    function htfd_pkg::res_rec_t measure(logic [7:0] check, logic qty);
      htfd_pkg::res_rec_t r;
      int raw;
      int val;
      raw = int'({high_byte, low_byte});
      if (qty == htfd_pkg::QTY_HUM) begin
        val = (10000 * raw) / 65535;
      end else begin
        val = (17500 * raw) / 65535 - 4500;
      end
      r.quantity     = qty;
      r.raw_word     = {high_byte, low_byte};
      r.crc_good     = (word_crc(high_byte, low_byte) == check);
      r.scaled_value = val[14:0];
      r.frame_done   = (qty == htfd_pkg::QTY_HUM);
      return r;
    endfunction

    // Note one accepted input beat.
    function void note_byte(logic [7:0] b);
      case (position)
        3'd1, 3'd4: begin
          low_byte = b;
          position = position + 3'd1;
        end
        3'd2: begin
          result_q.push_back(measure(b, htfd_pkg::QTY_TEMP));
          position = 3'd3;
        end
        3'd3: begin
          high_byte = b;
          position  = 3'd4;
        end
        3'd5: begin
          result_q.push_back(measure(b, htfd_pkg::QTY_HUM));
          position = 3'd0;
        end
        default: begin
          high_byte = b;
          position  = 3'd1;
        end
      endcase
    endfunction

    // Compare one accepted result beat with the oldest expectation.
    function void check_result(htfd_pkg::res_rec_t got);
      htfd_pkg::res_rec_t want;
      if (result_q.size() == 0) begin
        $error("unexpected result: raw_word %0h", got.raw_word);
        errors++;
        return;
      end
      want = result_q.pop_front();
      if (got.quantity !== want.quantity) begin
        $error("quantity expected %0d actual %0d", want.quantity, got.quantity);
        errors++;
      end
      if (got.raw_word !== want.raw_word) begin
        $error("raw_word expected %0h actual %0h", want.raw_word, got.raw_word);
        errors++;
      end
      if (got.crc_good !== want.crc_good) begin
        $error("crc_good expected %0d actual %0d", want.crc_good, got.crc_good);
        errors++;
      end
      if (got.scaled_value !== want.scaled_value) begin
        $error("scaled_value expected %0d actual %0d",
               want.scaled_value, got.scaled_value);
        errors++;
      end
      if (got.frame_done !== want.frame_done) begin
        $error("frame_done expected %0d actual %0d",
               want.frame_done, got.frame_done);
        errors++;
      end
    endfunction

    function int outstanding();
      return result_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic pop = 1'b0;
  logic full;
  logic empty;
  logic out_quantity;
  logic [15:0] out_raw_word;
  logic out_crc_good;
  logic signed [14:0] out_scaled_value;
  logic out_frame_done;

  frame_scoreboard sb = new();
  int cycle_count = 0;
  int burst_left = 0;

  humidity_temp_frame_decoder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .in_data_byte     (in_data_byte),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .out_quantity     (out_quantity),
    .out_raw_word     (out_raw_word),
    .out_crc_good     (out_crc_good),
    .out_scaled_value (out_scaled_value),
    .out_frame_done   (out_frame_done)
  );

  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Watch both queues; a beat moves on an edge with the handshake met.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        sb.note_byte(in_data_byte);
      end
      if (pop && !empty) begin
        sb.check_result('{quantity: out_quantity, raw_word: out_raw_word,
                          crc_good: out_crc_good, scaled_value: out_scaled_value,
                          frame_done: out_frame_done});
      end
    end
  end

  // Receiver: phases of steady popping, random popping, rare popping and a
  // periodic stall pattern.
  int pop_mode = 0;
  int pop_phase_left = 0;
  always @(posedge clk) begin
    if (pop_phase_left == 0) begin
      pop_mode       = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 3);
      pop_phase_left = $urandom_range(20, 200);
    end
    pop_phase_left = pop_phase_left - 1;
    case (pop_mode)
      0: pop <= 1'b1;
      1: pop <= 1'($urandom_range(0, 1));
      2: pop <= ($urandom_range(0, 7) == 0);
      default: pop <= ((cycle_count % 16) < 4);
    endcase
  end

  // Send one byte as an input beat, opening a new burst after a random gap,
  // sometimes none, when the current one is used up.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left = burst_left - 1;
    push         <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (full);
  endtask

  task automatic send_frame(input logic [15:0] t_raw, input logic [7:0] t_chk,
                            input logic [15:0] h_raw, input logic [7:0] h_chk);
    send_byte(t_raw[15:8]);
    send_byte(t_raw[7:0]);
    send_byte(t_chk);
    send_byte(h_raw[15:8]);
    send_byte(h_raw[7:0]);
    send_byte(h_chk);
  endtask

  function automatic logic [7:0] good_crc(logic [15:0] w);
    return frame_scoreboard::word_crc(w[15:8], w[7:0]);
  endfunction

  // Hold the sender until every expected result has been popped.
  task automatic wait_for_drain();
    push <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // Random word, biased now and then toward the ends and the middle of the range.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {1'b1, 15'h0000};
      3: return {1'b0, 15'h7FFF};
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Main stimulus.
  initial begin
    logic [15:0] tw;
    logic [15:0] hw;
    logic [7:0] tc;
    logic [7:0] hc;
    int kind;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme, mid-range and fixed words with good and failing check bytes.
    send_frame(16'h0000, good_crc(16'h0000), 16'hFFFF, good_crc(16'hFFFF));
    send_frame(16'hFFFF, good_crc(16'hFFFF) ^ 8'h01,
               16'h0000, good_crc(16'h0000) ^ 8'h80);
    send_frame(16'h8000, 8'hFF, 16'h7FFF, 8'h00);
    send_frame(16'hBEEF, good_crc(16'hBEEF), 16'h6666, good_crc(16'h6666));
    wait_for_drain();

    // Random frames: mostly well formed, some with damaged check bytes and
    // some with arbitrary check bytes.
    for (int f = 0; f < RANDOM_FRAMES; f++) begin
      kind = $urandom_range(0, 99);
      tw = pick_word();
      hw = pick_word();
      tc = good_crc(tw);
      hc = good_crc(hw);
      if (kind >= 70 && kind < 88) begin
        if ($urandom_range(0, 1)) tc = tc ^ (8'h01 << $urandom_range(0, 7));
        else hc = hc ^ (8'h01 << $urandom_range(0, 7));
      end else if (kind >= 88) begin
        tc = 8'($urandom_range(0, 255));
        hc = 8'($urandom_range(0, 255));
      end
      send_frame(tw, tc, hw, hc);
      if ((f % 60) == 59) begin
        wait_for_drain();
      end
    end
    push <= 1'b0;

    // Let the decoder empty, then watch a little longer for strays.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
